// ===== design/rmf_pkg.sv =====
// Shared constants and control types for the running median filter.
// No dependencies; used by rmf_sort and running_median_filter_unit.
package rmf_pkg;

   // Default window length and sample width (signed Q16.16).
   localparam int WINDOW_DEFAULT = 8;
   localparam int DATA_W         = 32;

   // Request from the control logic to the sorted-window engine.
   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] old_val;
      logic signed [DATA_W-1:0] new_val;
   } rmf_sort_req_type;

   // Completion from the sorted-window engine: the two middle elements.
   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
   } rmf_sort_rsp_type;

endpackage

// ===== design/running_median_filter_unit.sv =====
// Running median filter over a circular window of signed Q16.16 samples.
// Depends on rmf_pkg and instantiates rmf_sort.
//
// Usage:
//   The req_ channel carries one sample per request (req_sample). Each request
//   overwrites the oldest window entry and yields one response on the rsp_
//   channel (rsp_median) holding the median of the window. For an even window
//   the median is the mean of the two middle elements, rounded toward minus
//   infinity.
//   A request is taken when req_valid is high and req_stall is low; a response
//   is taken when rsp_valid is high and rsp_stall is low.
//   One request is processed at a time: rsp_valid rises once the merge pass over
//   the sorted memory has written every entry and dropped the displaced sample.
//   The next request is accepted as soon as the current one has been moved into
//   the response register.
//   If the receiver stalls, the finished response holds in the output register
//   and a following request waits in the final step until that register frees.
//   Reset empties the window to zeros and points the write pointer at entry 0;
//   those zeros take part in the median until WINDOW samples have arrived.
module running_median_filter_unit
   import rmf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_median
);

   localparam int   PTR_W  = $clog2(WINDOW);
   localparam logic IS_ODD = (WINDOW % 2) == 1;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_SORT = 2'd2;
   localparam logic [1:0] T_OUT  = 2'd3;

   logic signed [DATA_W-1:0] win_mem [WINDOW];
   logic [WINDOW-1:0]        wval_ff;
   logic signed [DATA_W-1:0] win_q_ff;
   logic                     win_qv_ff;

   logic [1:0]               state_ff, state_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic signed [DATA_W-1:0] new_ff, new_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_median_ff, rsp_median_in;

   logic                     req_accept;
   logic                     win_wr;
   logic signed [DATA_W:0]   pair_sum;
   logic signed [DATA_W-1:0] median_val;
   rmf_sort_req_type         sort_req;
   rmf_sort_rsp_type         sort_rsp;

   assign req_stall  = (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign win_wr     = (state_ff == T_READ);

   // Hand the displaced and the new sample to the sorted-window engine.
   assign sort_req.start   = win_wr;
   assign sort_req.old_val = win_qv_ff ? win_q_ff : '0;
   assign sort_req.new_val = new_ff;

   rmf_sort #(
      .WINDOW (WINDOW)
   ) u_sort (
      .clock    (clock),
      .reset    (reset),
      .sort_req (sort_req),
      .sort_rsp (sort_rsp)
   );

   // Median from the two middle elements; the sum keeps one extra bit.
   assign pair_sum   = {sort_rsp.lo[DATA_W-1], sort_rsp.lo}
                     + {sort_rsp.hi[DATA_W-1], sort_rsp.hi};
   assign median_val = IS_ODD ? sort_rsp.hi : pair_sum[DATA_W:1];

   // Request sequencing and the response register.
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               new_in   = req_sample;
               state_in = T_READ;
            end
         end
         T_READ: begin
            wp_in    = (wp_ff == PTR_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
            state_in = T_SORT;
         end
         T_SORT: begin
            if (sort_rsp.done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = median_val;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      new_ff        <= new_in;
      rsp_median_ff <= rsp_median_in;
   end

   // Valid bit for each window entry; unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         wval_ff <= '0;
      end else if (win_wr) begin
         wval_ff[wp_ff] <= 1'b1;
      end
   end

   // Window memory: the oldest entry is read, then overwritten by the new sample.
   always_ff @(posedge clock) begin
      if (win_wr) begin
         win_mem[wp_ff] <= new_ff;
      end
      win_q_ff  <= win_mem[wp_ff];
      win_qv_ff <= wval_ff[wp_ff];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // The engine reports completion only while a request is being sorted.
   a_done_in_sort : assert property (@(posedge clock) disable iff (reset)
      sort_rsp.done |-> (state_ff == T_SORT))
      else $error("sort completion outside the sort step");

   // Every window update advances the write pointer.
   a_wp_advance : assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_READ) |=> (wp_ff != $past(wp_ff)))
      else $error("write pointer did not advance");

   // A new response is loaded only from the final step.
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == T_OUT))
      else $error("response loaded outside the final step");

   // A stalled response is never overwritten by the next median.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_median_ff)))
      else $error("stalled response changed");

endmodule

// ===== design/rmf_sort.sv =====
// Sorted copy of the window kept in a ping-pong memory, updated by a merge pass.
// Depends on rmf_pkg for the data width and the request and completion types.
module rmf_sort
   import rmf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  rmf_sort_req_type sort_req,
   output rmf_sort_rsp_type sort_rsp
);

   localparam int IDX_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SORT_DEPTH = 2 ** (IDX_W + 1);
   localparam int LO_POS     = (WINDOW - 1) / 2;
   localparam int HI_POS     = WINDOW / 2;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_MERGE = 1'b1;

   logic signed [DATA_W-1:0] sort_mem [SORT_DEPTH];
   logic [SORT_DEPTH-1:0]    sval_ff;
   logic signed [DATA_W-1:0] mem_q_ff;
   logic                     mem_qv_ff;

   logic                     state_ff, state_in;
   logic                     bank_ff, bank_in;
   logic [CNT_W-1:0]         rd_ff, rd_in;
   logic [CNT_W-1:0]         wr_ff, wr_in;
   logic                     removed_ff, removed_in;
   logic                     inserted_ff, inserted_in;
   logic                     done_ff, done_in;
   logic signed [DATA_W-1:0] old_ff, old_in;
   logic signed [DATA_W-1:0] new_ff, new_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;

   logic                     exhausted;
   logic signed [DATA_W-1:0] head;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_data;
   logic [IDX_W:0]           rd_addr;
   logic [IDX_W:0]           wr_addr;

   // Entries never written since reset read as zero.
   assign head      = mem_qv_ff ? mem_q_ff : '0;
   assign exhausted = (rd_ff == CNT_W'(WINDOW));
   assign rd_addr   = {bank_ff, rd_in[IDX_W-1:0]};
   assign wr_addr   = {~bank_ff, wr_ff[IDX_W-1:0]};

   // Merge pass: drop one copy of the old sample and insert the new one in order.
   always_comb begin
      state_in    = state_ff;
      bank_in     = bank_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      removed_in  = removed_ff;
      inserted_in = inserted_ff;
      done_in     = 1'b0;
      old_in      = old_ff;
      new_in      = new_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      wr_en       = 1'b0;
      wr_data     = head;
      case (state_ff)
         S_IDLE: begin
            rd_in = '0;
            if (sort_req.start) begin
               old_in      = sort_req.old_val;
               new_in      = sort_req.new_val;
               removed_in  = 1'b0;
               inserted_in = 1'b0;
               wr_in       = '0;
               state_in    = S_MERGE;
            end
         end
         S_MERGE: begin
            if (!exhausted && !removed_ff && (head == old_ff)) begin
               removed_in = 1'b1;
               rd_in      = rd_ff + 1'b1;
            end else if (!inserted_ff && (exhausted || (new_ff < head))) begin
               wr_en       = 1'b1;
               wr_data     = new_ff;
               inserted_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_data = head;
               if (!exhausted) begin
                  rd_in = rd_ff + 1'b1;
               end
            end
            if (wr_en) begin
               wr_in = wr_ff + 1'b1;
               if (wr_ff == CNT_W'(LO_POS)) begin
                  lo_in = wr_data;
               end
               if (wr_ff == CNT_W'(HI_POS)) begin
                  hi_in = wr_data;
               end
               if (wr_ff == CNT_W'(WINDOW - 1)) begin
                  state_in = S_IDLE;
                  bank_in  = ~bank_ff;
                  done_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         bank_ff     <= 1'b0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         removed_ff  <= 1'b0;
         inserted_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bank_ff     <= bank_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         removed_ff  <= removed_in;
         inserted_ff <= inserted_in;
         done_ff     <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      old_ff <= old_in;
      new_ff <= new_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   // Valid bit for each memory entry, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sval_ff <= '0;
      end else if (wr_en) begin
         sval_ff[wr_addr] <= 1'b1;
      end
   end

   // Sorted memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sort_mem[wr_addr] <= wr_data;
      end
      mem_q_ff  <= sort_mem[rd_addr];
      mem_qv_ff <= sval_ff[rd_addr];
   end

   assign sort_rsp.done = done_ff;
   assign sort_rsp.lo   = lo_ff;
   assign sort_rsp.hi   = hi_ff;

endmodule

// ===== bench/median_window_checker.sv =====
// Checker for the running median filter: watches both channels, keeps its own window,
// predicts each median and compares it with the response. Depends on rmf_pkg.
`timescale 1ns / 1ps

module median_window_checker
   import rmf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_median,
   output int                       fail_count,
   output int                       pending
);

   typedef logic signed [DATA_W-1:0] sample_type;

   sample_type  window_samples [WINDOW];
   int unsigned oldest_slot = 0;
   sample_type  pending_medians [$];
   int          mismatch_count = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
      foreach (window_samples[i]) window_samples[i] = '0;
   end

   // Sorts a copy of the window and picks the middle; an even window averages
   // the two middle entries at one extra bit and rounds toward minus infinity.
   function automatic sample_type window_median(input sample_type win [WINDOW]);
      sample_type             ranked [WINDOW];
      sample_type             key;
      logic signed [DATA_W:0] pair_sum;
      int                     j;
      ranked = win;
      for (int i = 1; i < WINDOW; i++) begin
         key = ranked[i];
         j   = i - 1;
         while (j >= 0) begin
            if (ranked[j] <= key) break;
            ranked[j + 1] = ranked[j];
            j--;
         end
         ranked[j + 1] = key;
      end
      if (WINDOW % 2 == 0) begin
         pair_sum = ranked[WINDOW / 2 - 1] + ranked[WINDOW / 2];
         pair_sum = pair_sum >>> 1;
         return pair_sum[DATA_W-1:0];
      end
      return ranked[(WINDOW - 1) / 2];
   endfunction

   // Every accepted request updates the window and queues its median; every
   // accepted response is checked against the oldest queued median.
   always @(posedge clock) begin : watch
      sample_type predicted;
      if (reset) begin
         foreach (window_samples[i]) window_samples[i] = '0;
         oldest_slot = 0;
         pending_medians.delete();
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            window_samples[oldest_slot] = req_sample;
            oldest_slot = (oldest_slot + 1) % WINDOW;
            pending_medians.push_back(window_median(window_samples));
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_medians.size() == 0) begin
               $error("rsp_median: no request outstanding, expected none, actual %0d",
                      rsp_median);
               mismatch_count++;
            end else begin
               predicted = pending_medians.pop_front();
               if (rsp_median !== predicted) begin
                  $error("rsp_median mismatch: expected %0d, actual %0d", predicted, rsp_median);
                  mismatch_count++;
               end
            end
         end
      end
      fail_count <= mismatch_count;
      pending    <= pending_medians.size();
   end

endmodule

// ===== bench/tb_running_median_filter_unit.sv =====
// Top of the running median filter testbench: clock, reset, sample stimulus and verdict.
// Depends on rmf_pkg, running_median_filter_unit and median_window_checker.
`timescale 1ns / 1ps

module tb_running_median_filter_unit;
   import rmf_pkg::*;

   localparam int WINDOW         = WINDOW_DEFAULT;
   localparam int RANDOM_SAMPLES = 1400;
   localparam int QUIET_TAIL     = 150;
   localparam int CYCLE_LIMIT    = 400000;

   typedef logic signed [DATA_W-1:0] sample_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   sample_type req_sample = '0;
   logic       rsp_stall  = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   sample_type rsp_median;

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   running_median_filter_unit #(.WINDOW(WINDOW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median)
   );

   median_window_checker #(.WINDOW(WINDOW)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver mixes free stretches with stall bursts until the quiet tail.
   initial begin : stall_driver
      int run;
      run = 1;
      forever begin
         repeat (run) @(posedge clock);
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 40);
         end else begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 15);
         end
      end
   end

   // Random samples: full range, small values that tie and give odd sums,
   // the extremes, and ordinary Q16.16 magnitudes.
   function automatic sample_type random_sample();
      int whole;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 8) - 4;
         6: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               default: return -1;
            endcase
         end
         7, 8: begin
            whole = int'($urandom_range(0, 400)) - 200;
            return (whole <<< 16) + $urandom_range(0, 65535);
         end
         default: begin
            if ($urandom_range(0, 1) == 0) return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            return 32'sh8000_0000 + $urandom_range(0, 3);
         end
      endcase
   endfunction

   // Presents one request, after an optional idle burst, and waits until it is taken.
   task automatic send_sample(input sample_type value);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   initial begin : stimulus
      sample_type directed [$];
      // Small values first, so the reset zeros still dominate the window.
      directed = {32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000};
      // A window full of the maximum, then one full of the minimum, passing
      // through mixed windows whose middle pair sums to minus one.
      repeat (WINDOW) directed.push_back(32'sh7FFF_FFFF);
      repeat (WINDOW) directed.push_back(32'sh8000_0000);
      directed = {directed, -32'sd1, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_sample(directed[i]);
      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         if (i == RANDOM_SAMPLES - QUIET_TAIL) quiet <= 1'b1;
         send_sample(random_sample());
      end
      req_valid <= 1'b0;

      // Drain the outstanding medians, then allow one more pass of latency.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (WINDOW + 8) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
